// ----- design/qau_pkg.sv -----
// Shared types and constants of the quaternion attitude update core.
`timescale 1ns / 1ps
package qau_pkg;

   localparam int QW     = 32;   // quaternion part width, Q1.30
   localparam int DVD_W  = 61;   // divider dividend and quotient width
   localparam int DCNT_W = 6;    // divider iteration count width

   localparam logic signed [QW-1:0] Q_ONE = 32'sd1073741824;

   localparam logic [1:0] MODE_UPDATE = 2'd0;
   localparam logic [1:0] MODE_RELOAD = 2'd1;
   localparam logic [1:0] MODE_NORM   = 2'd2;

   localparam logic [3:0] SERIES_TERMS = 4'd9;

   typedef enum logic [1:0] {
      SA_ANGLE,
      SA_ATT,
      SA_U,
      SA_MAT
   } a_sel_type;

   typedef enum logic [1:0] {
      SB_ANGLE,
      SB_ATT,
      SB_SER,
      SB_F
   } b_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [4:0] {
      ACT_NONE,
      ACT_RELOAD,
      ACT_U,
      ACT_SER_INIT,
      ACT_SER_DIV,
      ACT_SER_END,
      ACT_SER_SAVE,
      ACT_CLAMP,
      ACT_B,
      ACT_ROW_WR,
      ACT_COMMIT,
      ACT_SQRT_INIT,
      ACT_SQRT_STEP,
      ACT_NDIV,
      ACT_NEND,
      ACT_ZERO,
      ACT_OUT
   } act_type;

   typedef struct packed {
      logic       load_item;
      logic       mul_en;
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      logic [1:0] a_idx;
      logic [1:0] b_idx;
      acc_op_type acc_op;
      act_type    act;
      logic [1:0] wr_idx;
      logic [3:0] k;
      logic       odd;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic norm_zero;
   } status_type;

endpackage

// ----- design/qau_req_if.sv -----
// Request channel: command mode and gyro increment angles.
`timescale 1ns / 1ps
interface qau_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [31:0] angle_x;
   logic signed [31:0] angle_y;
   logic signed [31:0] angle_z;

   modport source (output valid, mode, angle_x, angle_y, angle_z, input ready);
   modport sink (input valid, mode, angle_x, angle_y, angle_z, output ready);
endinterface

// ----- design/qau_rsp_if.sv -----
// Response channel: attitude quaternion and zero-norm flag.
`timescale 1ns / 1ps
interface qau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] quat_w;
   logic signed [31:0] quat_x;
   logic signed [31:0] quat_y;
   logic signed [31:0] quat_z;
   logic               norm_zero;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, norm_zero, input ready);
   modport sink (input valid, quat_w, quat_x, quat_y, quat_z, norm_zero, output ready);
endinterface

// ----- design/qau_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module qau_div import qau_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DCNT_W-1:0] count,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [31:0]       divisor,
   output logic              done,
   output logic [DVD_W-1:0]  quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]       rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [31:0]       dvs_ff, dvs_in;
   logic [32:0]       rem_sh;
   logic [32:0]       diff;
   logic              ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DVD_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      ge      = (rem_sh >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = count;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[31:0] : rem_sh[31:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- design/qau_dp.sv -----
// Datapath: attitude state, shared multiplier, accumulator, root and divide units.
`timescale 1ns / 1ps
module qau_dp import qau_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic signed [31:0] req_angle_x,
   input  logic signed [31:0] req_angle_y,
   input  logic signed [31:0] req_angle_z,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wr_data,
   output logic signed [31:0] rsp_quat_w,
   output logic signed [31:0] rsp_quat_x,
   output logic signed [31:0] rsp_quat_y,
   output logic signed [31:0] rsp_quat_z,
   output logic               rsp_norm_zero
);

   // ceil(2^45 / d) for each Horner divisor; exact quotient for dividends below 2^36
   localparam logic [63:0] RCP_ONE = 64'd1 << 45;
   localparam logic [44:0] RCP_2   = 45'((RCP_ONE + 64'd1) / 64'd2);
   localparam logic [44:0] RCP_6   = 45'((RCP_ONE + 64'd5) / 64'd6);
   localparam logic [44:0] RCP_12  = 45'((RCP_ONE + 64'd11) / 64'd12);
   localparam logic [44:0] RCP_20  = 45'((RCP_ONE + 64'd19) / 64'd20);
   localparam logic [44:0] RCP_30  = 45'((RCP_ONE + 64'd29) / 64'd30);
   localparam logic [44:0] RCP_42  = 45'((RCP_ONE + 64'd41) / 64'd42);
   localparam logic [44:0] RCP_56  = 45'((RCP_ONE + 64'd55) / 64'd56);
   localparam logic [44:0] RCP_72  = 45'((RCP_ONE + 64'd71) / 64'd72);
   localparam logic [44:0] RCP_90  = 45'((RCP_ONE + 64'd89) / 64'd90);
   localparam logic [44:0] RCP_110 = 45'((RCP_ONE + 64'd109) / 64'd110);
   localparam logic [44:0] RCP_132 = 45'((RCP_ONE + 64'd131) / 64'd132);
   localparam logic [44:0] RCP_156 = 45'((RCP_ONE + 64'd155) / 64'd156);
   localparam logic [44:0] RCP_182 = 45'((RCP_ONE + 64'd181) / 64'd182);
   localparam logic [44:0] RCP_210 = 45'((RCP_ONE + 64'd209) / 64'd210);
   localparam logic [44:0] RCP_240 = 45'((RCP_ONE + 64'd239) / 64'd240);
   localparam logic [44:0] RCP_272 = 45'((RCP_ONE + 64'd271) / 64'd272);
   localparam logic [44:0] RCP_306 = 45'((RCP_ONE + 64'd305) / 64'd306);
   localparam logic [44:0] RCP_342 = 45'((RCP_ONE + 64'd341) / 64'd342);

   function automatic logic signed [67:0] trunc30(input logic signed [67:0] v);
      logic signed [67:0] adj;
      adj = v + (v[67] ? 68'sd1073741823 : 68'sd0);
      return adj >>> 30;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
      logic signed [31:0] r;
      if (v > 70'sd2147483647) r = 32'sh7fffffff;
      else if (v < -70'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // Horner divisors: (2k-1)(2k) for the cosine, (2k)(2k+1) for sin(x)/x
   function automatic logic [44:0] series_rcp(input logic [3:0] k, input logic odd);
      logic [44:0] m;
      case (k)
         4'd1:    m = odd ? RCP_6   : RCP_2;
         4'd2:    m = odd ? RCP_20  : RCP_12;
         4'd3:    m = odd ? RCP_42  : RCP_30;
         4'd4:    m = odd ? RCP_72  : RCP_56;
         4'd5:    m = odd ? RCP_110 : RCP_90;
         4'd6:    m = odd ? RCP_156 : RCP_132;
         4'd7:    m = odd ? RCP_210 : RCP_182;
         4'd8:    m = odd ? RCP_272 : RCP_240;
         4'd9:    m = odd ? RCP_342 : RCP_306;
         default: m = '0;
      endcase
      return m;
   endfunction

   logic signed [31:0] att_ff [4], att_in [4];
   logic signed [31:0] cfg_ff [4], cfg_in [4];
   logic signed [31:0] ang_ff [3], ang_in [3];
   logic signed [31:0] b_ff [3], b_in [3];
   logic signed [31:0] nq_ff [4], nq_in [4];
   logic signed [31:0] out_ff [4], out_in [4];
   logic               out_zero_ff, out_zero_in;
   logic               zero_ff, zero_in;
   logic [31:0]        u_ff, u_in;
   logic signed [33:0] ser_ff, ser_in;
   logic signed [33:0] c_ff, c_in;
   logic signed [33:0] p_ff, p_in;
   logic [29:0]        f_ff, f_in;
   logic signed [67:0] prod_ff, prod_in;
   logic signed [67:0] acc_ff, acc_in;
   logic [63:0]        t_ff, t_in;
   logic [35:0]        rem_ff, rem_in;
   logic [31:0]        root_ff, root_in;
   logic               div_neg_ff, div_neg_in;
   logic [35:0]        cdx_ff, cdx_in;
   logic [44:0]        cdm_ff, cdm_in;
   logic [62:0]        cdlo_ff, cdlo_in;
   logic [62:0]        cdhi_ff, cdhi_in;
   logic [35:0]        cdq_ff, cdq_in;
   logic [1:0]         cdph_ff, cdph_in;
   logic               cddone_ff, cddone_in;

   logic signed [33:0] opa, opb, mat_val;
   logic               mat_c, mat_neg;
   logic [1:0]         mat_b;
   logic signed [67:0] tprod, tacc, tmag;
   logic signed [37:0] qser, ser_new;
   logic signed [69:0] qnorm;
   logic signed [33:0] pcl;
   logic [35:0]        rem_sh, trial;
   logic [31:0]        amag;
   logic [17:0]        cdop;
   logic [62:0]        cdprod;
   logic [80:0]        cdsum;
   logic               div_start, div_done;
   logic [DCNT_W-1:0]  div_count;
   logic [DVD_W-1:0]   div_dividend, div_quotient;
   logic [31:0]        div_divisor;

   qau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .count    (div_count),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // rotation matrix entry: row a_idx, column b_idx
   always_comb begin
      mat_c   = 1'b0;
      mat_neg = 1'b0;
      mat_b   = 2'd0;
      case ({cmd.a_idx, cmd.b_idx})
         4'b0000, 4'b0101, 4'b1010, 4'b1111: mat_c = 1'b1;
         4'b0001: begin mat_b = 2'd0; mat_neg = 1'b1; end
         4'b0010: begin mat_b = 2'd1; mat_neg = 1'b1; end
         4'b0011: begin mat_b = 2'd2; mat_neg = 1'b1; end
         4'b0100: mat_b = 2'd0;
         4'b0110: mat_b = 2'd2;
         4'b0111: begin mat_b = 2'd1; mat_neg = 1'b1; end
         4'b1000: mat_b = 2'd1;
         4'b1001: begin mat_b = 2'd2; mat_neg = 1'b1; end
         4'b1011: mat_b = 2'd0;
         4'b1100: mat_b = 2'd2;
         4'b1101: mat_b = 2'd1;
         4'b1110: begin mat_b = 2'd0; mat_neg = 1'b1; end
         default: mat_c = 1'b1;
      endcase
      mat_val = mat_c ? c_ff : 34'(b_ff[mat_b]);
      if (mat_neg) mat_val = -mat_val;
   end

   always_comb begin
      case (cmd.a_sel)
         SA_ANGLE: opa = 34'(ang_ff[cmd.a_idx]);
         SA_ATT:   opa = 34'(att_ff[cmd.a_idx]);
         SA_U:     opa = $signed({2'b00, u_ff});
         SA_MAT:   opa = mat_val;
         default:  opa = '0;
      endcase
      case (cmd.b_sel)
         SB_ANGLE: opb = 34'(ang_ff[cmd.b_idx]);
         SB_ATT:   opb = 34'(att_ff[cmd.b_idx]);
         SB_SER:   opb = ser_ff;
         SB_F:     opb = $signed({4'b0000, f_ff});
         default:  opb = '0;
      endcase
      prod_in = opa * opb;
   end

   always_comb begin
      tprod   = trunc30(prod_ff);
      tacc    = trunc30(acc_ff);
      tmag    = tprod[67] ? -tprod : tprod;
      qser    = div_neg_ff ? -$signed({2'b00, cdq_ff}) : $signed({2'b00, cdq_ff});
      ser_new = 38'sd1073741824 - qser;
      qnorm   = div_neg_ff ? -$signed({9'd0, div_quotient})
                           : $signed({9'd0, div_quotient});
      pcl     = p_ff[33] ? 34'sd0 : ((p_ff > 34'sd1073741824) ? 34'sd1073741824 : p_ff);
      rem_sh  = {rem_ff[33:0], t_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      amag    = att_ff[cmd.wr_idx][31] ? 32'(-att_ff[cmd.wr_idx]) : 32'(att_ff[cmd.wr_idx]);

      div_start    = (cmd.act == ACT_NDIV);
      div_count    = DCNT_W'(61);
      div_dividend = {amag, 29'd0};
      div_divisor  = root_ff;
   end

   // series step divide: reciprocal multiply in two 18-bit halves, low half first, then high half, then their sum
   always_comb begin
      cdx_in    = cdx_ff;
      cdm_in    = cdm_ff;
      cdlo_in   = cdlo_ff;
      cdhi_in   = cdhi_ff;
      cdq_in    = cdq_ff;
      cdph_in   = cdph_ff;
      cddone_in = 1'b0;
      cdop      = (cdph_ff == 2'd1) ? cdx_ff[17:0] : cdx_ff[35:18];
      cdprod    = {45'd0, cdop} * {18'd0, cdm_ff};
      cdsum     = {cdhi_ff, 18'd0} + {18'd0, cdlo_ff};
      case (cdph_ff)
         2'd1: begin
            cdlo_in = cdprod;
            cdph_in = 2'd2;
         end
         2'd2: begin
            cdhi_in = cdprod;
            cdph_in = 2'd3;
         end
         2'd3: begin
            cdq_in    = cdsum[80:45];
            cddone_in = 1'b1;
            cdph_in   = 2'd0;
         end
         default: ;
      endcase
      if (cmd.act == ACT_SER_DIV) begin
         cdx_in  = tmag[35:0];
         cdm_in  = series_rcp(cmd.k, cmd.odd);
         cdph_in = 2'd1;
      end
   end

   always_comb begin
      att_in      = att_ff;
      cfg_in      = cfg_ff;
      ang_in      = ang_ff;
      b_in        = b_ff;
      nq_in       = nq_ff;
      out_in      = out_ff;
      out_zero_in = out_zero_ff;
      zero_in     = zero_ff;
      u_in        = u_ff;
      ser_in      = ser_ff;
      c_in        = c_ff;
      p_in        = p_ff;
      f_in        = f_ff;
      acc_in      = acc_ff;
      t_in        = t_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      div_neg_in  = div_neg_ff;

      if (csr_wr_en) cfg_in[csr_index] = csr_wr_data;

      if (cmd.load_item) begin
         ang_in[0] = req_angle_x;
         ang_in[1] = req_angle_y;
         ang_in[2] = req_angle_z;
         zero_in   = 1'b0;
      end

      case (cmd.acc_op)
         ACC_LOAD: acc_in = prod_ff;
         ACC_ADD:  acc_in = acc_ff + prod_ff;
         default:  acc_in = acc_ff;
      endcase

      unique case (cmd.act)
         ACT_NONE: ;
         ACT_RELOAD:   att_in = cfg_ff;
         ACT_U:        u_in = acc_ff[63:32];
         ACT_SER_INIT: ser_in = 34'sd1073741824;
         ACT_SER_DIV:  div_neg_in = prod_ff[67];
         ACT_SER_END:  ser_in = ser_new[33:0];
         ACT_SER_SAVE: begin
            if (cmd.odd) p_in = ser_ff;
            else c_in = ser_ff;
         end
         ACT_CLAMP: begin
            if (c_ff > 34'sd1073741824) c_in = 34'sd1073741824;
            else if (c_ff < -34'sd1073741824) c_in = -34'sd1073741824;
            f_in = pcl[30:1];
         end
         ACT_B:      b_in[cmd.wr_idx] = tprod[31:0];
         ACT_ROW_WR: nq_in[cmd.wr_idx] = sat32({{2{tacc[67]}}, tacc});
         ACT_COMMIT: att_in = nq_ff;
         ACT_SQRT_INIT: begin
            t_in    = acc_ff[65:2];
            rem_in  = '0;
            root_in = '0;
         end
         ACT_SQRT_STEP: begin
            t_in = {t_ff[61:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[30:0], 1'b0};
            end
         end
         ACT_NDIV: div_neg_in = att_ff[cmd.wr_idx][31];
         ACT_NEND: att_in[cmd.wr_idx] = sat32(qnorm);
         ACT_ZERO: zero_in = 1'b1;
         ACT_OUT: begin
            out_in      = att_ff;
            out_zero_in = zero_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         att_ff[0] <= Q_ONE;
         att_ff[1] <= '0;
         att_ff[2] <= '0;
         att_ff[3] <= '0;
         cfg_ff[0] <= Q_ONE;
         cfg_ff[1] <= '0;
         cfg_ff[2] <= '0;
         cfg_ff[3] <= '0;
         cdph_ff   <= '0;
         cddone_ff <= 1'b0;
      end else begin
         att_ff    <= att_in;
         cfg_ff    <= cfg_in;
         cdph_ff   <= cdph_in;
         cddone_ff <= cddone_in;
      end
   end

   always_ff @(posedge clock) begin
      ang_ff      <= ang_in;
      b_ff        <= b_in;
      nq_ff       <= nq_in;
      out_ff      <= out_in;
      out_zero_ff <= out_zero_in;
      zero_ff     <= zero_in;
      u_ff        <= u_in;
      ser_ff      <= ser_in;
      c_ff        <= c_in;
      p_ff        <= p_in;
      f_ff        <= f_in;
      acc_ff      <= acc_in;
      t_ff        <= t_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      div_neg_ff  <= div_neg_in;
      cdx_ff      <= cdx_in;
      cdm_ff      <= cdm_in;
      cdlo_ff     <= cdlo_in;
      cdhi_ff     <= cdhi_in;
      cdq_ff      <= cdq_in;
      if (cmd.mul_en) prod_ff <= prod_in;
   end

   assign status.div_done  = div_done | cddone_ff;
   assign status.norm_zero = (root_ff == 32'd0);

   assign rsp_quat_w    = out_ff[0];
   assign rsp_quat_x    = out_ff[1];
   assign rsp_quat_y    = out_ff[2];
   assign rsp_quat_z    = out_ff[3];
   assign rsp_norm_zero = out_zero_ff;

endmodule

// ----- design/qau_ctrl.sv -----
// Controller: sequences the datapath through each command's steps.
`timescale 1ns / 1ps
module qau_ctrl import qau_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_mode,
   output logic       req_ready,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [19:0] {
      S_IDLE      = 20'h00001,
      S_RELOAD    = 20'h00002,
      S_SQ        = 20'h00004,
      S_U         = 20'h00008,
      S_SER_INIT  = 20'h00010,
      S_SER_MUL   = 20'h00020,
      S_SER_DIV   = 20'h00040,
      S_SER_WAIT  = 20'h00080,
      S_SER_SAVE  = 20'h00100,
      S_CLAMP     = 20'h00200,
      S_BVEC      = 20'h00400,
      S_ROW       = 20'h00800,
      S_ROW_WR    = 20'h01000,
      S_COMMIT    = 20'h02000,
      S_SQRT_INIT = 20'h04000,
      S_SQRT      = 20'h08000,
      S_NCHECK    = 20'h10000,
      S_NDIV      = 20'h20000,
      S_NWAIT     = 20'h40000,
      S_DONE      = 20'h80000
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   logic [3:0] k_ff, k_in;
   logic       odd_ff, odd_in;
   logic [1:0] mode_ff, mode_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] sq_last;
   logic       upd;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      odd_in       = odd_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.k        = k_ff;
      cmd.odd      = odd_ff;
      upd          = (mode_ff == MODE_UPDATE);
      sq_last      = upd ? 5'd3 : 5'd4;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               mode_in       = req_mode;
               cnt_in        = '0;
               case (req_mode)
                  MODE_UPDATE, MODE_NORM: state_in = S_SQ;
                  MODE_RELOAD:            state_in = S_RELOAD;
                  default:                state_in = S_DONE;
               endcase
            end
         end
         S_RELOAD: begin
            cmd.act  = ACT_RELOAD;
            state_in = S_DONE;
         end
         // sum of squares: multiply term n while accumulating term n-1
         S_SQ: begin
            if (cnt_ff != sq_last) begin
               cmd.mul_en = 1'b1;
               cmd.a_sel  = upd ? SA_ANGLE : SA_ATT;
               cmd.b_sel  = upd ? SB_ANGLE : SB_ATT;
               cmd.a_idx  = cnt_ff[1:0];
               cmd.b_idx  = cnt_ff[1:0];
            end
            if (cnt_ff != 5'd0) cmd.acc_op = (cnt_ff == 5'd1) ? ACC_LOAD : ACC_ADD;
            if (cnt_ff == sq_last) state_in = upd ? S_U : S_SQRT_INIT;
            else cnt_in = cnt_ff + 5'd1;
         end
         S_U: begin
            cmd.act  = ACT_U;
            odd_in   = 1'b0;
            state_in = S_SER_INIT;
         end
         S_SER_INIT: begin
            cmd.act  = ACT_SER_INIT;
            k_in     = SERIES_TERMS;
            state_in = S_SER_MUL;
         end
         S_SER_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.a_sel  = SA_U;
            cmd.b_sel  = SB_SER;
            state_in   = S_SER_DIV;
         end
         S_SER_DIV: begin
            cmd.act  = ACT_SER_DIV;
            state_in = S_SER_WAIT;
         end
         S_SER_WAIT: begin
            if (status.div_done) begin
               cmd.act = ACT_SER_END;
               if (k_ff == 4'd1) begin
                  state_in = S_SER_SAVE;
               end else begin
                  k_in     = k_ff - 4'd1;
                  state_in = S_SER_MUL;
               end
            end
         end
         S_SER_SAVE: begin
            cmd.act = ACT_SER_SAVE;
            if (odd_ff) begin
               state_in = S_CLAMP;
            end else begin
               odd_in   = 1'b1;
               state_in = S_SER_INIT;
            end
         end
         S_CLAMP: begin
            cmd.act  = ACT_CLAMP;
            cnt_in   = '0;
            state_in = S_BVEC;
         end
         S_BVEC: begin
            if (cnt_ff != 5'd3) begin
               cmd.mul_en = 1'b1;
               cmd.a_sel  = SA_ANGLE;
               cmd.b_sel  = SB_F;
               cmd.a_idx  = cnt_ff[1:0];
            end
            if (cnt_ff != 5'd0) begin
               cmd.act    = ACT_B;
               cmd.wr_idx = cnt_ff[1:0] - 2'd1;
            end
            if (cnt_ff == 5'd3) begin
               idx_in   = '0;
               cnt_in   = '0;
               state_in = S_ROW;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_ROW: begin
            if (cnt_ff != 5'd4) begin
               cmd.mul_en = 1'b1;
               cmd.a_sel  = SA_MAT;
               cmd.b_sel  = SB_ATT;
               cmd.a_idx  = idx_ff;
               cmd.b_idx  = cnt_ff[1:0];
            end
            if (cnt_ff != 5'd0) cmd.acc_op = (cnt_ff == 5'd1) ? ACC_LOAD : ACC_ADD;
            if (cnt_ff == 5'd4) state_in = S_ROW_WR;
            else cnt_in = cnt_ff + 5'd1;
         end
         S_ROW_WR: begin
            cmd.act    = ACT_ROW_WR;
            cmd.wr_idx = idx_ff;
            cnt_in     = '0;
            if (idx_ff == 2'd3) begin
               state_in = S_COMMIT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_ROW;
            end
         end
         S_COMMIT: begin
            cmd.act  = ACT_COMMIT;
            state_in = S_DONE;
         end
         S_SQRT_INIT: begin
            cmd.act  = ACT_SQRT_INIT;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.act = ACT_SQRT_STEP;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = S_NCHECK;
         end
         S_NCHECK: begin
            idx_in = '0;
            if (status.norm_zero) begin
               cmd.act  = ACT_ZERO;
               state_in = S_DONE;
            end else begin
               state_in = S_NDIV;
            end
         end
         S_NDIV: begin
            cmd.act    = ACT_NDIV;
            cmd.wr_idx = idx_ff;
            state_in   = S_NWAIT;
         end
         S_NWAIT: begin
            cmd.wr_idx = idx_ff;
            if (status.div_done) begin
               cmd.act = ACT_NEND;
               if (idx_ff == 2'd3) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = S_NDIV;
               end
            end
         end
         S_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.act      = ACT_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      k_ff    <= k_in;
      odd_ff  <= odd_in;
      mode_ff <= mode_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/quaternion_attitude_update_core.sv -----
// Quaternion attitude update core: propagates an attitude quaternion by gyro
// increment angles (mode 0), reloads it from the start registers (mode 1) or
// normalizes it (mode 2); every transaction returns the quaternion after the step.
// One transaction at a time. In mode 0 the cosine and sin(x)/x series run nine
// Horner steps each, and every step is a multiply plus a reciprocal multiply by
// its constant divisor. Mode 2 runs a 32-step square root, then four divisions
// by the norm (none when the norm is zero). A new request is taken while the
// previous response still waits in the output register; the next response is
// then held until that register is free.
`timescale 1ns / 1ps
module quaternion_attitude_update_core import qau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   qau_req_if.sink     req,
   qau_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   qau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_mode  (req.mode),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .cmd       (cmd),
      .status    (status)
   );

   qau_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_angle_x   (req.angle_x),
      .req_angle_y   (req.angle_y),
      .req_angle_z   (req.angle_z),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .rsp_quat_w    (rsp.quat_w),
      .rsp_quat_x    (rsp.quat_x),
      .rsp_quat_y    (rsp.quat_y),
      .rsp_quat_z    (rsp.quat_z),
      .rsp_norm_zero (rsp.norm_zero)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request taken while a transaction is in progress");

   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |-> req.valid && req.ready)
      else $error("item latched without a request handshake");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.act == ACT_OUT |-> !rsp.valid || rsp.ready)
      else $error("pending response overwritten");

endmodule
